// File: hw/rtl/odqks_pkg.sv
// shared constants, codes and control structs for the ordered deque with key search
package odqks_pkg;

   localparam int CAPACITY_DEF     = 16;
   localparam int RECORD_BYTES_DEF = 8;

   localparam int TYPE_W   = 3;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int OFF_W    = 3;
   localparam int KCNT_W   = 4;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_INS_HEAD = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INS_TAIL = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_REM_HEAD = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_REM_TAIL = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_SEARCH   = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_REM_KEY  = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

   // register indexes
   localparam logic CSR_KEY_OFFSET = 1'b0;
   localparam logic CSR_KEY_COUNT  = 1'b1;

   typedef struct packed {
      logic                load;
      logic                idx_clear;
      logic                idx_last;
      logic                idx_inc;
      logic                rd;
      logic                insert;
      logic                remove;
      logic                res_set;
      logic                res_take_rd;
      logic [STATUS_W-1:0] res_status;
      logic                out_load;
   } cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic              full;
      logic              empty;
      logic              idx_end;
      logic              match;
      logic              out_free;
   } stat_type;

endpackage

// File: hw/rtl/odqks_req_if.sv
// request channel: valid, ready and the request payload
interface odqks_req_if import odqks_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [DATA_W-1:0] record;
   logic [DATA_W-1:0] search_key;

   modport source (output valid, req_type, record, search_key, input ready);
   modport sink   (input valid, req_type, record, search_key, output ready);
endinterface

// File: hw/rtl/odqks_rsp_if.sv
// response channel: valid, ready and the result payload
interface odqks_rsp_if import odqks_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   record_out;
   logic [COUNT_W-1:0]  entry_count;
   logic                is_empty;

   modport source (output valid, status, record_out, entry_count, is_empty, input ready);
   modport sink   (input valid, status, record_out, entry_count, is_empty, output ready);
endinterface

// File: hw/rtl/odqks_ram.sv
// generic single write port ram with registered read
module odqks_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/odqks_ctrl.sv
// controller state machine: sequences dispatch, entry walk and response
module odqks_ctrl import odqks_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       forced;

   assign req_ready = (state_ff == S_IDLE);
   assign forced = (stat.req_type == REQ_REM_HEAD) || (stat.req_type == REQ_REM_TAIL);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.req_type)
               REQ_INS_HEAD, REQ_INS_TAIL: begin
                  cmd.res_set = 1'b1;
                  if (stat.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.insert     = 1'b1;
                     cmd.res_status = ST_DONE;
                  end
                  state_in = S_RESP;
               end
               REQ_REM_HEAD, REQ_REM_TAIL, REQ_SEARCH, REQ_REM_KEY: begin
                  if (stat.empty) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_MISS;
                     state_in       = S_RESP;
                  end else begin
                     if (stat.req_type == REQ_REM_TAIL) begin
                        cmd.idx_last = 1'b1;
                     end else begin
                        cmd.idx_clear = 1'b1;
                     end
                     state_in = S_READ;
                  end
               end
               default: begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_MISS;
                  state_in       = S_RESP;
               end
            endcase
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            priority if (forced || stat.match) begin
               cmd.res_set     = 1'b1;
               cmd.res_take_rd = 1'b1;
               cmd.res_status  = ST_DONE;
               cmd.remove      = (stat.req_type != REQ_SEARCH);
               state_in        = S_RESP;
            end else if (stat.idx_end) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_RESP;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_READ;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: hw/rtl/odqks_dpath.sv
// datapath: order map, record ram, key compare, result and output registers
module odqks_dpath import odqks_pkg::*; #(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [OFF_W-1:0]  key_pos,
   input  logic [KCNT_W-1:0] key_count,
   odqks_req_if.sink         req,
   odqks_rsp_if.source       rsp
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [DATA_W-1:0] REC_MASK =
      (RECORD_BYTES >= 8) ? {DATA_W{1'b1}} : ((DATA_W'(1) << (8 * RECORD_BYTES)) - DATA_W'(1));

   logic [TYPE_W-1:0]   type_ff;
   logic [DATA_W-1:0]   rec_ff;
   logic [DATA_W-1:0]   key_ff;
   logic [IW-1:0]       links_ff [CAPACITY];
   logic [CW-1:0]       count_ff;
   logic [IW-1:0]       idx_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [DATA_W-1:0]   res_rec_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_rec_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_empty_ff;

   logic [IW-1:0]     free_slot;
   logic [IW-1:0]     idx_slot;
   logic [DATA_W-1:0] rd_data;
   logic [DATA_W-1:0] key_sh;
   logic [7:0]        byte_ok;
   logic [CW-1:0]     last_pos;

   assign free_slot = links_ff[count_ff[IW-1:0]];
   assign idx_slot  = links_ff[idx_ff];
   assign last_pos  = count_ff - CW'(1);

   odqks_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (free_slot),
      .wr_data (rec_ff),
      .rd_en   (cmd.rd),
      .rd_addr (idx_slot),
      .rd_data (rd_data)
   );

   // key bytes lined up with record bytes; disabled bytes always agree
   assign key_sh = key_ff << {key_pos, 3'b000};
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         byte_ok[j] = (rd_data[8*j +: 8] == key_sh[8*j +: 8])
                   || !(KCNT_W'(j) >= KCNT_W'(key_pos))
                   || !((KCNT_W'(j) - KCNT_W'(key_pos)) < key_count)
                   || (j >= RECORD_BYTES);
      end
   end

   assign stat.req_type = type_ff;
   assign stat.full     = (count_ff == CW'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.idx_end  = (CW'(idx_ff) == last_pos);
   assign stat.match    = &byte_ok;
   assign stat.out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req.req_type;
         rec_ff  <= req.record & REC_MASK;
         key_ff  <= req.search_key;
      end
      if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_last) begin
         idx_ff <= last_pos[IW-1:0];
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IW'(1);
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_rec_ff    <= cmd.res_take_rd ? (rd_data & REC_MASK) : '0;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_rec_ff    <= res_rec_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CAPACITY; i++) begin
            links_ff[i] <= IW'(i);
         end
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.insert) begin
            count_ff <= count_ff + CW'(1);
            if (type_ff == REQ_INS_HEAD) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (i == 0) begin
                     links_ff[i] <= free_slot;
                  end else if (CW'(i) <= count_ff) begin
                     links_ff[i] <= links_ff[(i > 0) ? i - 1 : 0];
                  end
               end
            end
         end else if (cmd.remove) begin
            count_ff <= last_pos;
            for (int i = 0; i < CAPACITY; i++) begin
               if (CW'(i) == last_pos) begin
                  links_ff[i] <= idx_slot;
               end else if ((i + 1 < CAPACITY) && (IW'(i) >= idx_ff)
                            && (CW'(i) < last_pos)) begin
                  links_ff[i] <= links_ff[(i + 1 < CAPACITY) ? i + 1 : i];
               end
            end
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.record_out  = rsp_rec_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.is_empty    = rsp_empty_ff;
endmodule

// File: hw/rtl/ordered_deque_with_key_search.sv
// top level of the ordered deque with key search
// a bounded double-ended queue of records with head and tail insert and
// remove, plus search or remove of the first record whose key matches
// req channel: one item per request (req_type, record, search_key)
// rsp channel: one item per request (status, record_out, entry_count, is_empty)
// inserts and empty or full refusals pass through dispatch and response;
// head and tail removes add a read state and a compare state before the response
// a key walk passes read and compare for each entry (order map lookup, ram read,
// compare) until a match or the last entry
// one request is worked at a time; the next is taken once the current
// result sits in the output register, even if rsp is stalled
// a stalled rsp holds the result; a second finished result waits in the
// result register, with the controller held, until the output register frees
// reset clears the count, the order map and the key settings (offset 0,
// count 1); record contents are left as they are
// key registers are written over the apb-style port at 0 and 4
module ordered_deque_with_key_search import odqks_pkg::*; #(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   odqks_req_if.sink         req,
   odqks_rsp_if.source       rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);
   logic [OFF_W-1:0]  key_pos_ff;
   logic [KCNT_W-1:0] key_count_ff;
   logic              csr_wr;
   cmd_type           cmd;
   stat_type          stat;

   // register write on the access phase
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff   <= '0;
         key_count_ff <= KCNT_W'(1);
      end else if (csr_wr) begin
         unique case (paddr[2])
            CSR_KEY_OFFSET: key_pos_ff   <= pwdata[OFF_W-1:0];
            CSR_KEY_COUNT:  key_count_ff <= pwdata[KCNT_W-1:0];
            default:        key_count_ff <= key_count_ff;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (paddr[2])
         CSR_KEY_OFFSET: prdata = CSR_DW'(key_pos_ff);
         CSR_KEY_COUNT:  prdata = CSR_DW'(key_count_ff);
         default:        prdata = '0;
      endcase
   end

   // sequencer
   odqks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // order map, record store and result path
   odqks_dpath #(.CAPACITY(CAPACITY), .RECORD_BYTES(RECORD_BYTES)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .key_pos   (key_pos_ff),
      .key_count (key_count_ff),
      .req       (req),
      .rsp       (rsp)
   );
endmodule

// File: test/odqks_tb_pkg.sv
// testbench item types used by the checker
package odqks_tb_pkg;
   import odqks_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   record_out;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
   } outcome_type;
endpackage

// File: test/odqks_deque_checker.sv
// checker: mirrors the deque from the channels and compares every result
module odqks_deque_checker import odqks_pkg::*; import odqks_tb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   odqks_req_if          req,
   odqks_rsp_if          rsp,
   input  logic          cfg_wr,
   input  logic          cfg_addr_sel,
   input  logic [31:0]   cfg_data,
   output int            fail_count,
   output int            pending_count,
   output int            result_count,
   output int            found_count
);
   logic [DATA_W-1:0] slot_data [CAPACITY_DEF];
   int unsigned       slot_order [CAPACITY_DEF];
   int unsigned       held;
   int unsigned       key_off;
   int unsigned       key_len;
   outcome_type       awaited [$];

   function automatic bit key_hit(logic [DATA_W-1:0] rec, logic [DATA_W-1:0] key);
      int unsigned pos;
      for (int unsigned i = 0; i < key_len && i < 8; i++) begin
         pos = key_off + i;
         if (pos >= RECORD_BYTES_DEF) break;
         if (rec[8*pos +: 8] != key[8*i +: 8]) return 0;
      end
      return 1;
   endfunction

   function automatic logic [DATA_W-1:0] take_position(int unsigned p);
      int unsigned s;
      s = slot_order[p];
      for (int unsigned i = p; i + 1 < held; i++) slot_order[i] = slot_order[i+1];
      held--;
      slot_order[held] = s;
      return slot_data[s];
   endfunction

   function automatic outcome_type deque_outcome(logic [TYPE_W-1:0] kind,
                                                 logic [DATA_W-1:0] rec,
                                                 logic [DATA_W-1:0] key);
      outcome_type o;
      int unsigned s;
      o = '0;
      o.status = ST_MISS;
      case (kind)
         REQ_INS_HEAD, REQ_INS_TAIL: begin
            if (held >= CAPACITY_DEF) o.status = ST_FULL;
            else begin
               s = slot_order[held];
               slot_data[s] = rec;
               if (kind == REQ_INS_HEAD) begin
                  for (int unsigned i = held; i > 0; i--) slot_order[i] = slot_order[i-1];
                  slot_order[0] = s;
               end
               held++;
               o.status = ST_DONE;
            end
         end
         REQ_REM_HEAD, REQ_REM_TAIL: begin
            if (held > 0) begin
               o.record_out = take_position(kind == REQ_REM_HEAD ? 0 : held - 1);
               o.status = ST_DONE;
            end
         end
         REQ_SEARCH, REQ_REM_KEY: begin
            for (int unsigned i = 0; i < held; i++) begin
               if (key_hit(slot_data[slot_order[i]], key)) begin
                  if (kind == REQ_REM_KEY) o.record_out = take_position(i);
                  else o.record_out = slot_data[slot_order[i]];
                  o.status = ST_DONE;
                  break;
               end
            end
         end
         default: ;
      endcase
      o.entry_count = COUNT_W'(held);
      o.is_empty = (held == 0);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         for (int i = 0; i < CAPACITY_DEF; i++) slot_order[i] = i;
         held = 0;
         key_off = 0;
         key_len = 1;
         awaited.delete();
         fail_count <= 0;
         result_count <= 0;
         found_count <= 0;
      end else begin
         if (cfg_wr) begin
            if (cfg_addr_sel == CSR_KEY_OFFSET) key_off = cfg_data[OFF_W-1:0];
            else key_len = cfg_data[KCNT_W-1:0];
         end
         if (req.valid && req.ready)
            awaited.push_back(deque_outcome(req.req_type, req.record, req.search_key));
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.status, rsp.record_out, rsp.entry_count, rsp.is_empty};
            result_count <= result_count + 1;
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited.pop_front();
               if (want.status == ST_DONE) found_count <= found_count + 1;
               if (got !== want) begin
                  $display("%0t: mismatch expected st=%0d rec=%h cnt=%0d emp=%0d", $time,
                           want.status, want.record_out, want.entry_count, want.is_empty);
                  $display("%0t:            actual st=%0d rec=%h cnt=%0d emp=%0d", $time,
                           got.status, got.record_out, got.entry_count, got.is_empty);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= awaited.size();
   end
endmodule

// File: test/ordered_deque_with_key_search_tb.sv
// stimulus top: clock, reset, key register phases and request traffic
module ordered_deque_with_key_search_tb import odqks_pkg::*; ();
   logic              clock = 0;
   logic              reset = 1;
   logic              psel = 0, penable = 0, pwrite = 0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   int                fail_count, pending_count, result_count, found_count;
   int                idle_cycles = 0;
   int                sent = 0;
   logic [DATA_W-1:0] recent_keys [8];
   logic [3:0]        stall_pattern;
   logic [3:0]        next_pattern;
   bit                drop_valid = 0;

   odqks_req_if req ();
   odqks_rsp_if rsp ();

   ordered_deque_with_key_search dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // register writes seen by the checker at the access edge
   odqks_deque_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .cfg_wr(psel && penable && pwrite && pready),
      .cfg_addr_sel(paddr[2]), .cfg_data(pwdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count), .found_count(found_count)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.req_type = '0;
      req.record = '0;
      req.search_key = '0;
      rsp.ready = 0;
      stall_pattern = 4'b1011;
   end

   // receiver stalls on a rotating pattern, reshuffled now and then, with clean stretches
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else begin
         next_pattern = {stall_pattern[2:0], stall_pattern[3]};
         if ($urandom_range(0, 63) == 0) next_pattern = 4'($urandom);
         if ($urandom_range(0, 199) < 3) next_pattern = 4'hf;
         stall_pattern <= next_pattern;
         rsp.ready <= stall_pattern[0];
      end
   end

   // watchdog: cycles with no accepted item on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_key_reg(logic sel, logic [CSR_DW-1:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= sel == CSR_KEY_OFFSET ? CSR_AW'(0) : CSR_AW'(4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // drops valid after the last item of a burst, only when the sender waits
   task automatic go_idle();
      if (drop_valid) begin
         req.valid <= 0;
         drop_valid = 0;
      end
   endtask

   // waits until every result is back, then lets a key walk drain
   task automatic drain();
      go_idle();
      while (pending_count != 0 || req.valid) @(posedge clock);
      repeat (2 * CAPACITY_DEF + 10) @(posedge clock);
   endtask

   // one request; valid stays up between back to back items
   task automatic send(logic [TYPE_W-1:0] kind, logic [DATA_W-1:0] rec,
                       logic [DATA_W-1:0] key, bit keep);
      drop_valid = 0;
      req.valid <= 1;
      req.req_type <= kind;
      req.record <= rec;
      req.search_key <= key;
      do @(posedge clock); while (!req.ready);
      if (!keep) drop_valid = 1;
      sent++;
   endtask

   // searches mostly aim at keys of recently inserted records
   task automatic random_item(bit keep);
      logic [TYPE_W-1:0] kind;
      logic [DATA_W-1:0] rec, key;
      int                pick;
      rec = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) rec[63:8] = '0;
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = pick[0] ? REQ_INS_TAIL : REQ_INS_HEAD;
      else if (pick < 55) kind = pick[0] ? REQ_REM_TAIL : REQ_REM_HEAD;
      else if (pick < 97) kind = pick[0] ? REQ_REM_KEY : REQ_SEARCH;
      else kind = TYPE_W'($urandom_range(6, 7));
      key = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : recent_keys[$urandom_range(0, 7)];
      // key is aligned at byte 0, the checker shifts by the offset
      key = key >> ($urandom_range(0, 1) ? 0 : 8 * $urandom_range(0, 7));
      if (kind inside {REQ_INS_HEAD, REQ_INS_TAIL}) recent_keys[$urandom_range(0, 7)] = rec;
      send(kind, rec, key, keep);
   endtask

   initial begin
      int phase_items;
      for (int i = 0; i < 8; i++) recent_keys[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: empty refusals, fill to full, extremes, key cases
      send(REQ_REM_HEAD, '0, '0, 0);
      send(REQ_REM_TAIL, '0, '0, 0);
      send(REQ_SEARCH, '0, '0, 0);
      send(REQ_REM_KEY, '1, '1, 0);
      for (int i = 0; i < CAPACITY_DEF; i++)
         send(i[0] ? REQ_INS_TAIL : REQ_INS_HEAD,
              i == 0 ? '1 : i == 1 ? '0 : {32'($urandom), 24'($urandom), 8'(i)}, '0, 1);
      send(REQ_INS_TAIL, 64'h5a, '0, 1);
      send(REQ_INS_HEAD, 64'h5a, '0, 1);
      send(REQ_SEARCH, '0, 64'hff, 1);
      send(REQ_REM_KEY, '0, 64'h05, 1);
      send(REQ_REM_KEY, '0, 64'h77, 1);
      send(3'd6, '1, '1, 1);
      send(3'd7, '0, '0, 1);
      send(REQ_REM_TAIL, '0, '0, 0);
      send(REQ_REM_HEAD, '0, '0, 0);
      drain();

      // key setting phases, extremes first, then random, back to defaults
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin write_key_reg(CSR_KEY_OFFSET, 7); write_key_reg(CSR_KEY_COUNT, 8); end
            1: begin write_key_reg(CSR_KEY_OFFSET, 0); write_key_reg(CSR_KEY_COUNT, 8); end
            2: begin write_key_reg(CSR_KEY_OFFSET, 3); write_key_reg(CSR_KEY_COUNT, 0); end
            3: begin write_key_reg(CSR_KEY_OFFSET, 5); write_key_reg(CSR_KEY_COUNT, 15); end
            9: begin write_key_reg(CSR_KEY_OFFSET, 0); write_key_reg(CSR_KEY_COUNT, 1); end
            default: begin
               write_key_reg(CSR_KEY_OFFSET, $urandom);
               write_key_reg(CSR_KEY_COUNT, $urandom);
            end
         endcase
         phase_items = 0;
         while (phase_items < 102) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) random_item(b + 1 < burst);
            phase_items += burst;
            // gaps between bursts, sometimes none
            if ($urandom_range(0, 3) != 0) begin
               go_idle();
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end
            if ($urandom_range(0, 40) == 0) begin
               go_idle();
               while (pending_count != 0) @(posedge clock);
            end
         end
         drain();
      end

      $display("covered %0d requests over 10 key settings, %0d results, %0d completed",
               sent, result_count, found_count);
      if (fail_count == 0 && pending_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// File: ordered_deque_with_key_search.f
hw/rtl/odqks_pkg.sv
hw/rtl/odqks_req_if.sv
hw/rtl/odqks_rsp_if.sv
hw/rtl/odqks_ram.sv
hw/rtl/odqks_ctrl.sv
hw/rtl/odqks_dpath.sv
hw/rtl/ordered_deque_with_key_search.sv
test/odqks_tb_pkg.sv
test/odqks_deque_checker.sv
test/ordered_deque_with_key_search_tb.sv
